// File: rtl/dcpp_pkg.sv
`timescale 1ns / 1ps

package dcpp_pkg;

    localparam int unsigned SLOW_W = 24;
    localparam int unsigned RATE_W = 40;
    localparam int unsigned DEN_W  = 25;
    localparam int unsigned PROD_W = 39;
    localparam int unsigned CNT_W  = 6;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_INC    = 2'd1;
    localparam logic [1:0] MODE_DEC    = 2'd2;

    localparam logic [2:0] CFG_BACKOFF_UNIT = 3'd0;
    localparam logic [2:0] CFG_DIVISOR      = 3'd1;
    localparam logic [2:0] CFG_MIN_WINDOW   = 3'd2;
    localparam logic [2:0] CFG_THRESHOLD    = 3'd3;
    localparam logic [2:0] CFG_RANDOMIZE    = 3'd4;
    localparam logic [2:0] CFG_INITIAL_RATE = 3'd5;

    localparam logic [SLOW_W-1:0] SLOW_MAX   = 24'hFFFFFF;
    localparam logic [22:0]       RATE_SCALE = 23'd8000000;

    localparam logic [CNT_W-1:0] STEPS_SLOW = 6'd24;
    localparam logic [CNT_W-1:0] STEPS_RATE = 6'd40;

    typedef struct packed {
        logic [23:0] rtt_us;
        logic        ce_mark;
        logic [31:0] high_mark;
        logic [31:0] next_seq;
        logic [31:0] window;
        logic [15:0] segment_bytes;
        logic [15:0] backoff_draw;
    } t_req;

    typedef struct packed {
        logic        updated;
        logic [1:0]  mode;
        logic [23:0] slow_us;
        logic        pacing_on;
        logic [39:0] pacing_rate;
    } t_rsp;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  steps;
        logic [RATE_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: rtl/dcpp_req_if.sv
`timescale 1ns / 1ps

interface dcpp_req_if;
    logic            valid;
    logic            ready;
    dcpp_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/dcpp_rsp_if.sv
`timescale 1ns / 1ps

interface dcpp_rsp_if;
    logic            valid;
    logic            ready;
    dcpp_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/dcpp_div.sv
`timescale 1ns / 1ps

module dcpp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dcpp_pkg::t_div_req  i_req,
    output dcpp_pkg::t_div_rsp  o_rsp
);

    logic [dcpp_pkg::RATE_W-1:0] r_q;
    logic [dcpp_pkg::DEN_W-1:0]  r_rem;
    logic [dcpp_pkg::DEN_W-1:0]  r_d;
    logic [dcpp_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [dcpp_pkg::DEN_W:0]    shifted;
    logic [dcpp_pkg::DEN_W+1:0]  diff;
    logic                        borrow;

    assign shifted = {r_rem, r_q[dcpp_pkg::RATE_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_d};
    assign borrow  = diff[dcpp_pkg::DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_req.start) begin
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_d    <= i_req.divisor;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy) begin
                r_q    <= {r_q[dcpp_pkg::RATE_W-2:0], ~borrow};
                r_rem  <= borrow ? shifted[dcpp_pkg::DEN_W-1:0] : diff[dcpp_pkg::DEN_W-1:0];
                r_cnt  <= r_cnt - 6'd1;
                r_busy <= r_cnt != 6'd1;
                r_done <= r_cnt == 6'd1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

// File: rtl/dctcp_plus_pacing_state_machine.sv
`timescale 1ns / 1ps

// Backoff and pacing state machine for a congestion controller.
// Each request on i_req carries one acknowledgement event; each event yields
// exactly one response on o_rsp with the mode, slow time and pacing rate.
// Both channels use a valid/ready handshake. Configuration is written through
// i_cfg_we, i_cfg_idx and i_cfg_data; the user must write it only while no
// event is in flight, as the block itself does not enforce this.
// An event with a zero round-trip time goes from idle straight to the output
// state, and one that ends in normal mode passes the preparation state first.
// Other events run through one shared restoring divider: 40 steps for the
// rate, preceded by 24 steps when the slow time is divided. i_req.ready is
// high only between events, so a new request is not taken before the
// response of the previous event has been registered.
// Reset puts the mode in normal, the slow time at one, the rate at zero and
// pacing off, and loads the default register values.
// A finished response waits in the output register while the receiver
// stalls; the next request is taken meanwhile, but its response waits
// until the previous one has been taken.
module dctcp_plus_pacing_state_machine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [39:0]       i_cfg_data,
    dcpp_req_if.sink          i_req,
    dcpp_rsp_if.source        o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHRINK,
        S_PREP,
        S_RATE_WAIT,
        S_OUT
    } t_state;

    t_state r_state;

    logic [15:0] r_backoff_unit;
    logic [7:0]  r_divisor;
    logic [31:0] r_min_window;
    logic [23:0] r_threshold;
    logic        r_randomize;
    logic [39:0] r_initial_rate;

    logic [1:0]  r_mode;
    logic [23:0] r_slow;
    logic [39:0] r_rate;
    logic        r_pacing;
    logic        r_upd;
    logic [23:0] r_rtt;
    logic [15:0] r_seg;

    dcpp_pkg::t_rsp r_out;
    logic           r_out_valid;

    dcpp_pkg::t_div_req div_req;
    dcpp_pkg::t_div_rsp div_rsp;

    logic        accept;
    logic        has_rtt;
    logic [31:0] seq_diff;
    logic        cong;
    logic [15:0] backoff;
    logic [24:0] add_sum;
    logic [23:0] add_sat;
    logic [24:0] shrink_sum;
    logic [23:0] shrink_sat;
    logic        need_shrink;
    logic [1:0]  n_mode;
    logic [23:0] n_slow;
    logic [7:0]  div_eff;
    logic [38:0] prod;
    logic [24:0] den;

    assign accept   = i_req.valid && i_req.ready;
    assign has_rtt  = i_req.data.rtt_us != '0;
    assign seq_diff = i_req.data.high_mark - i_req.data.next_seq;
    assign cong     = i_req.data.ce_mark || !seq_diff[31];
    assign backoff  = r_randomize ? i_req.data.backoff_draw : r_backoff_unit;
    assign add_sum  = {1'b0, r_slow} + {9'd0, backoff};
    assign add_sat  = add_sum[24] ? dcpp_pkg::SLOW_MAX : add_sum[23:0];

    assign shrink_sum = {1'b0, div_rsp.quotient[23:0]} + 25'd1;
    assign shrink_sat = shrink_sum[24] ? dcpp_pkg::SLOW_MAX : shrink_sum[23:0];

    assign div_eff = (r_divisor == '0) ? 8'd1 : r_divisor;
    assign prod    = 39'(dcpp_pkg::RATE_SCALE) * 39'(r_seg);
    assign den     = {1'b0, r_rtt} + {1'b0, r_slow};

    always_comb begin
        n_mode      = r_mode;
        n_slow      = r_slow;
        need_shrink = 1'b0;
        case (r_mode)
            dcpp_pkg::MODE_INC: begin
                if (cong) begin
                    n_slow = add_sat;
                end else begin
                    n_mode      = dcpp_pkg::MODE_DEC;
                    need_shrink = 1'b1;
                end
            end
            dcpp_pkg::MODE_DEC: begin
                if (cong) begin
                    n_mode = dcpp_pkg::MODE_INC;
                    n_slow = add_sat;
                end else if (r_slow > r_threshold) begin
                    need_shrink = 1'b1;
                end else begin
                    n_mode = dcpp_pkg::MODE_NORMAL;
                end
            end
            default: begin
                n_mode = dcpp_pkg::MODE_NORMAL;
                if (i_req.data.window == r_min_window && cong) begin
                    n_mode = dcpp_pkg::MODE_INC;
                    n_slow = {8'd0, backoff};
                end
            end
        endcase
    end

    always_comb begin
        if (r_state == S_PREP) begin
            div_req.start    = r_mode != dcpp_pkg::MODE_NORMAL;
            div_req.steps    = dcpp_pkg::STEPS_RATE;
            div_req.dividend = {1'b0, prod};
            div_req.divisor  = den;
        end else begin
            div_req.start    = accept && has_rtt && need_shrink;
            div_req.steps    = dcpp_pkg::STEPS_SLOW;
            div_req.dividend = {r_slow, 16'd0};
            div_req.divisor  = {17'd0, div_eff};
        end
    end

    dcpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_backoff_unit <= 16'd100;
            r_divisor      <= 8'd2;
            r_min_window   <= 32'd1448;
            r_threshold    <= 24'd2;
            r_randomize    <= 1'b1;
            r_initial_rate <= '0;
            r_mode         <= dcpp_pkg::MODE_NORMAL;
            r_slow         <= 24'd1;
            r_rate         <= '0;
            r_pacing       <= 1'b0;
            r_upd          <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dcpp_pkg::CFG_BACKOFF_UNIT: r_backoff_unit <= i_cfg_data[15:0];
                    dcpp_pkg::CFG_DIVISOR:      r_divisor      <= i_cfg_data[7:0];
                    dcpp_pkg::CFG_MIN_WINDOW:   r_min_window   <= i_cfg_data[31:0];
                    dcpp_pkg::CFG_THRESHOLD:    r_threshold    <= i_cfg_data[23:0];
                    dcpp_pkg::CFG_RANDOMIZE:    r_randomize    <= i_cfg_data[0];
                    dcpp_pkg::CFG_INITIAL_RATE: r_initial_rate <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && o_rsp.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_rtt <= i_req.data.rtt_us;
                        r_seg <= i_req.data.segment_bytes;
                        if (has_rtt) begin
                            r_mode   <= n_mode;
                            r_slow   <= n_slow;
                            r_upd    <= 1'b1;
                            r_pacing <= 1'b1;
                            r_state  <= need_shrink ? S_SHRINK : S_PREP;
                        end else begin
                            r_upd   <= 1'b0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SHRINK: begin
                    if (div_rsp.done) begin
                        r_slow  <= shrink_sat;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    if (r_mode == dcpp_pkg::MODE_NORMAL) begin
                        r_rate  <= r_initial_rate;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_RATE_WAIT;
                    end
                end
                S_RATE_WAIT: begin
                    if (div_rsp.done) begin
                        r_rate  <= (div_rsp.quotient == '0) ? 40'd1 : div_rsp.quotient;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out.updated     <= r_upd;
                        r_out.mode        <= r_mode;
                        r_out.slow_us     <= r_slow;
                        r_out.pacing_on   <= r_pacing;
                        r_out.pacing_rate <= r_rate;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = r_state == S_IDLE;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_SHRINK || r_state == S_RATE_WAIT))
        else $error("divider finished outside a wait state");

    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_mode[1] && r_mode[0]))
        else $error("mode register holds an unused code");

    a_rate_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.mode != dcpp_pkg::MODE_NORMAL)
            |-> (o_rsp.data.pacing_rate != '0 && o_rsp.data.pacing_on))
        else $error("backoff mode reported with zero rate or pacing off");

    a_updated_pacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.updated) |-> o_rsp.data.pacing_on)
        else $error("updated response without pacing enabled");

endmodule
